// File: hw/rtl/frae_pkg.sv
// ---------------------------------------------------------------------------
// frae_pkg: shared types and constants for the four-register ALU executor
// Operation codes, the decoded instruction record and the queue sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package frae_pkg;

   localparam int unsigned OPNUM_WIDTH   = 4;
   localparam int unsigned OPERAND_WIDTH = 16;
   localparam int unsigned REG_IDX_WIDTH = 2;
   localparam int unsigned NUM_REGS      = 4;
   localparam int unsigned RESULT_WIDTH  = 32;
   localparam int unsigned OPMAP_WIDTH   = 64;

   localparam logic [OPMAP_WIDTH-1:0] OPMAP_RESET = 64'hFEDC_BA98_7654_3210;

   // Depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OPNUM_WIDTH-1:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [OPERAND_WIDTH-1:0]   src_a;
      logic [OPERAND_WIDTH-1:0]   src_b;
      logic [REG_IDX_WIDTH-1:0]   dest_index;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

`default_nettype wire

// File: hw/rtl/frae_req_if.sv
// ---------------------------------------------------------------------------
// frae_req_if: instruction channel
// Valid/ready channel carrying one instruction per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface frae_req_if;
   import frae_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OPNUM_WIDTH-1:0]    opcode;
   logic [OPERAND_WIDTH-1:0]  src_a;
   logic [OPERAND_WIDTH-1:0]  src_b;
   logic [REG_IDX_WIDTH-1:0]  dest_index;

   modport source (output valid, output opcode, output src_a, output src_b,
                   output dest_index, input ready);
   modport sink   (input valid, input opcode, input src_a, input src_b,
                   input dest_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/frae_rsp_if.sv
// ---------------------------------------------------------------------------
// frae_rsp_if: register snapshot channel
// Valid/ready channel carrying the four registers per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface frae_rsp_if;
   import frae_pkg::*;

   logic                            valid;
   logic                            ready;
   logic signed [RESULT_WIDTH-1:0]  r0_value;
   logic signed [RESULT_WIDTH-1:0]  r1_value;
   logic signed [RESULT_WIDTH-1:0]  r2_value;
   logic signed [RESULT_WIDTH-1:0]  r3_value;

   modport source (output valid, output r0_value, output r1_value,
                   output r2_value, output r3_value, input ready);
   modport sink   (input valid, input r0_value, input r1_value,
                   input r2_value, input r3_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/four_register_alu_executor_core.sv
// ---------------------------------------------------------------------------
// four_register_alu_executor_core: four-register ALU instruction executor
// Executes one instruction per beat on a four-entry register file and
// returns all four registers after each instruction.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one instruction per beat: an instruction number, which
//   the opcode map turns into an operation, operands A and B, and the
//   destination register. rsp_bus returns one beat per instruction holding
//   the low 32 bits of all four registers after it has executed.
//   csr_wr_en/csr_wr_data load the 64-bit opcode map; write it only while
//   no instruction is in flight.
//   An accepted beat is registered in the queue, and on retiring in the
//   register file and response valid. Throughput is one instruction per
//   cycle while the receiver takes each beat; the combinational ALU feeds
//   the register file, so dependent instructions follow without bubbles.
//   Reset clears the register file, empties the two-entry queue and loads
//   the identity opcode map. When the receiver stalls, the response beat is
//   held, the queue absorbs up to two further instructions and then
//   req_bus.ready falls.
// ---------------------------------------------------------------------------
`default_nettype none

module four_register_alu_executor_core #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   frae_req_if.sink                         req_bus,
   frae_rsp_if.source                       rsp_bus,
   input  wire                              csr_wr_en,
   input  wire [frae_pkg::OPMAP_WIDTH-1:0]  csr_wr_data
);
   import frae_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   frae_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push)
   );

   frae_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   frae_back #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// File: hw/rtl/frae_front.sv
// ---------------------------------------------------------------------------
// frae_front: instruction intake and decode
// Holds the opcode map, accepts instruction beats and translates the
// instruction number into an operation before queueing.
// ---------------------------------------------------------------------------
`default_nettype none

module frae_front (
   input  wire                                 clock,
   input  wire                                 reset,
   frae_req_if.sink                            req_bus,
   input  wire                                 csr_wr_en,
   input  wire [frae_pkg::OPMAP_WIDTH-1:0]     csr_wr_data,
   input  wire                                 queue_full,
   output frae_pkg::push_type                  push
);
   import frae_pkg::*;

   logic [OPMAP_WIDTH-1:0] opmap_ff;
   logic [OPMAP_WIDTH-1:0] opmap_in;

   always_comb begin
      opmap_in = opmap_ff;
      if (csr_wr_en) begin
         opmap_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opmap_ff <= OPMAP_RESET;
      end else begin
         opmap_ff <= opmap_in;
      end
   end

   assign req_bus.ready = !queue_full;

   always_comb begin
      push.push            = req_bus.valid && !queue_full;
      push.item.op         = op_type'(opmap_ff[OPNUM_WIDTH*req_bus.opcode +: OPNUM_WIDTH]);
      push.item.src_a      = req_bus.src_a;
      push.item.src_b      = req_bus.src_b;
      push.item.dest_index = req_bus.dest_index;
   end

endmodule

`default_nettype wire

// File: hw/rtl/frae_queue.sv
// ---------------------------------------------------------------------------
// frae_queue: decoded instruction queue
// Small FIFO between front and back; push and pop may share a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module frae_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  frae_pkg::push_type  push,
   input  wire                 pop,
   output logic                full,
   output frae_pkg::head_type  head
);
   import frae_pkg::*;

   item_type               store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] r;
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QUEUE_PTR_W'(1);
      end
      return r;
   endfunction

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = store_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop       ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = push.push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      count_in  = count_ff;
      if (push.push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push.push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         store_ff[wr_ptr_ff] <= push.item;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.push)
      else $error("queue pushed while full");

endmodule

`default_nettype wire

// File: hw/rtl/frae_back.sv
// ---------------------------------------------------------------------------
// frae_back: execute stage and register file
// Takes the queue head, applies the operation to the register file and
// presents the updated registers as one response beat.
// ---------------------------------------------------------------------------
`default_nettype none

module frae_back #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  frae_pkg::head_type  head,
   output logic                pop,
   frae_rsp_if.source          rsp_bus
);
   import frae_pkg::*;

   localparam int unsigned IMM_EXT_W = DATA_WIDTH + OPERAND_WIDTH;
   localparam int unsigned OUT_EXT_W = DATA_WIDTH + RESULT_WIDTH;

   logic [DATA_WIDTH-1:0] regs_ff [NUM_REGS];
   logic [DATA_WIDTH-1:0] regs_in [NUM_REGS];
   logic                  out_valid_ff;
   logic                  out_valid_in;

   logic [IMM_EXT_W-1:0]  imm_a_ext;
   logic [IMM_EXT_W-1:0]  imm_b_ext;
   logic [DATA_WIDTH-1:0] imm_a;
   logic [DATA_WIDTH-1:0] imm_b;
   logic [DATA_WIDTH-1:0] reg_a;
   logic [DATA_WIDTH-1:0] reg_b;
   logic [DATA_WIDTH-1:0] opnd_b;
   logic [DATA_WIDTH-1:0] cmp_x;
   logic [DATA_WIDTH-1:0] cmp_y;
   logic [DATA_WIDTH-1:0] mul_res;
   logic [DATA_WIDTH-1:0] result;
   logic                  gt_flag;
   logic                  eq_flag;
   logic [OUT_EXT_W-1:0]  out_ext [NUM_REGS];

   // Immediates are zero-extended, or truncated when the datapath is narrower.
   assign imm_a_ext = {{DATA_WIDTH{1'b0}}, head.item.src_a};
   assign imm_b_ext = {{DATA_WIDTH{1'b0}}, head.item.src_b};
   assign imm_a     = imm_a_ext[DATA_WIDTH-1:0];
   assign imm_b     = imm_b_ext[DATA_WIDTH-1:0];
   assign reg_a     = regs_ff[head.item.src_a[REG_IDX_WIDTH-1:0]];
   assign reg_b     = regs_ff[head.item.src_b[REG_IDX_WIDTH-1:0]];

   always_comb begin
      opnd_b = reg_b;
      cmp_x  = reg_a;
      cmp_y  = reg_b;
      case (head.item.op)
         OP_ADDI, OP_MULI, OP_BANI, OP_BORI: opnd_b = imm_b;
         default:                            opnd_b = reg_b;
      endcase
      case (head.item.op)
         OP_GTIR, OP_EQIR: begin
            cmp_x = imm_a;
            cmp_y = reg_b;
         end
         OP_GTRI, OP_EQRI: begin
            cmp_x = reg_a;
            cmp_y = imm_b;
         end
         default: begin
            cmp_x = reg_a;
            cmp_y = reg_b;
         end
      endcase
   end

   // Only the low word of the product is kept; above 32 bits the cross terms
   // are formed at the upper width alone.
   generate
      if (DATA_WIDTH <= 32) begin : g_mul_narrow
         assign mul_res = reg_a * opnd_b;
      end else begin : g_mul_wide
         localparam int unsigned HW = DATA_WIDTH - 32;
         logic [63:0] lo_prod;
         logic [HW-1:0] cross_sum;
         assign lo_prod   = reg_a[31:0] * opnd_b[31:0];
         assign cross_sum = reg_a[DATA_WIDTH-1:32] * opnd_b[HW-1:0]
                          + reg_a[HW-1:0] * opnd_b[DATA_WIDTH-1:32];
         assign mul_res   = lo_prod[DATA_WIDTH-1:0] + {cross_sum, 32'b0};
      end
   endgenerate

   assign gt_flag = $signed(cmp_x) > $signed(cmp_y);
   assign eq_flag = (cmp_x == cmp_y);

   always_comb begin
      result = '0;
      unique case (head.item.op)
         OP_ADDR, OP_ADDI: result = reg_a + opnd_b;
         OP_MULR, OP_MULI: result = mul_res;
         OP_BANR, OP_BANI: result = reg_a & opnd_b;
         OP_BORR, OP_BORI: result = reg_a | opnd_b;
         OP_SETR:          result = reg_a;
         OP_SETI:          result = imm_a;
         OP_GTIR, OP_GTRI, OP_GTRR: result = DATA_WIDTH'(gt_flag);
         OP_EQIR, OP_EQRI, OP_EQRR: result = DATA_WIDTH'(eq_flag);
      endcase
   end

   // The register file itself is the response payload, so an instruction is
   // only retired once the previous beat has left.
   assign pop = head.valid && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      for (int k = 0; k < NUM_REGS; k++) begin
         regs_in[k] = regs_ff[k];
      end
      if (pop) begin
         regs_in[head.item.dest_index] = result;
      end
      out_valid_in = pop || (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++) begin
            regs_ff[k] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < NUM_REGS; k++) begin
            regs_ff[k] <= regs_in[k];
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_REGS; k++) begin
         out_ext[k] = {{RESULT_WIDTH{1'b0}}, regs_ff[k]};
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.r0_value = out_ext[0][RESULT_WIDTH-1:0];
   assign rsp_bus.r1_value = out_ext[1][RESULT_WIDTH-1:0];
   assign rsp_bus.r2_value = out_ext[2][RESULT_WIDTH-1:0];
   assign rsp_bus.r3_value = out_ext[3][RESULT_WIDTH-1:0];

   a_pop_gives_beat: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_valid_ff)
      else $error("retired instruction produced no response beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |-> !pop)
      else $error("register file changed under a stalled beat");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (regs_ff[0] == '0) && (regs_ff[1] == '0) && (regs_ff[2] == '0)
                && (regs_ff[3] == '0) && !out_valid_ff)
      else $error("register file not cleared by reset");

endmodule

`default_nettype wire

// File: tb/sv/tb_four_register_alu_executor_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_four_register_alu_executor_core: self-checking bench for the ALU executor
// Drives instructions through the request channel under random idling and
// back-pressure, keeps a shadow register file and opcode map, and compares
// every register snapshot beat against the shadow's prediction.
// ---------------------------------------------------------------------------

module tb_four_register_alu_executor_core;
   import frae_pkg::*;

   typedef logic [NUM_REGS-1:0][RESULT_WIDTH-1:0] snap_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [OPMAP_WIDTH-1:0] csr_wr_data;

   frae_req_if req_bus ();
   frae_rsp_if rsp_bus ();

   four_register_alu_executor_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow state of the block.
   snap_type               shadow_regs = '0;
   logic [OPMAP_WIDTH-1:0] shadow_opmap = OPMAP_RESET;
   snap_type               expected_snaps[$];

   int  mismatch_count = 0;
   bit  tx_idle = 1'b1;
   bit  rx_idle = 1'b1;
   int  rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("four_register_alu_executor_core: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic snap_type apply_instruction(input logic [OPNUM_WIDTH-1:0] num,
                                                  input logic [15:0] a,
                                                  input logic [15:0] b,
                                                  input logic [1:0] dest);
      logic [31:0] ra;
      logic [31:0] rb;
      logic [31:0] ia;
      logic [31:0] ib;
      logic [31:0] res;
      op_type      op;
      ra = shadow_regs[a[1:0]];
      rb = shadow_regs[b[1:0]];
      ia = {16'h0000, a};
      ib = {16'h0000, b};
      op = op_type'(shadow_opmap[4*num +: 4]);
      case (op)
         OP_ADDR: res = ra + rb;
         OP_ADDI: res = ra + ib;
         OP_MULR: res = ra * rb;
         OP_MULI: res = ra * ib;
         OP_BANR: res = ra & rb;
         OP_BANI: res = ra & ib;
         OP_BORR: res = ra | rb;
         OP_BORI: res = ra | ib;
         OP_SETR: res = ra;
         OP_SETI: res = ia;
         OP_GTIR: res = ($signed(ia) > $signed(rb)) ? 32'd1 : 32'd0;
         OP_GTRI: res = ($signed(ra) > $signed(ib)) ? 32'd1 : 32'd0;
         OP_GTRR: res = ($signed(ra) > $signed(rb)) ? 32'd1 : 32'd0;
         OP_EQIR: res = (ia == rb) ? 32'd1 : 32'd0;
         OP_EQRI: res = (ra == ib) ? 32'd1 : 32'd0;
         default: res = (ra == rb) ? 32'd1 : 32'd0;
      endcase
      shadow_regs[dest] = res;
      return shadow_regs;
   endfunction

   // Offers one instruction; valid is left high so that a following item can
   // go out on the very next cycle.
   task automatic send_instr(input logic [OPNUM_WIDTH-1:0] num, input logic [15:0] a,
                             input logic [15:0] b, input logic [1:0] dest);
      int       gap;
      snap_type snap;
      gap = tx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= num;
      req_bus.src_a      <= a;
      req_bus.src_b      <= b;
      req_bus.dest_index <= dest;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      snap = apply_instruction(num, a, b, dest);
      expected_snaps.insert(expected_snaps.size(), snap);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_snaps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_opmap(input logic [OPMAP_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      shadow_opmap = value;
   endtask

   function automatic logic [15:0] draw_operand();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_instr();
      send_instr(4'($urandom), draw_operand(), draw_operand(), 2'($urandom));
   endtask

   // Receiver: while rx_idle is set a fresh stall is drawn after every beat; a long hold-off set
   // by a test is counted down here.
   initial begin : rsp_monitor
      snap_type got;
      snap_type want;
      int       stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.r3_value, rsp_bus.r2_value, rsp_bus.r1_value,
                   rsp_bus.r0_value};
            if (expected_snaps.size() == 0) begin
               report_mismatch("beat with nothing expected, r0_value", got[0], '0);
            end else begin
               want = expected_snaps.pop_front();
               for (int k = 0; k < NUM_REGS; k++) begin
                  if (got[k] !== want[k])
                     report_mismatch($sformatf("r%0d_value", k), got[k], want[k]);
               end
            end
            stall_left = rx_idle ? $urandom_range(0, 10) : 0;
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Every operation under the identity map, with wrap-around, signed
   // compares against negative registers and ignored high index bits.
   task automatic test_directed_ops();
      send_instr(OP_SETI, 16'hFFFF, 16'hFFFF, 2'd0);
      send_instr(OP_MULI, 16'h0000, 16'hFFFF, 2'd1);
      send_instr(OP_MULR, 16'h0001, 16'h0001, 2'd2);
      send_instr(OP_ADDR, 16'h0001, 16'h0002, 2'd3);
      send_instr(OP_ADDI, 16'hFFFD, 16'hFFFF, 2'd3);
      send_instr(OP_BANR, 16'h0000, 16'h0001, 2'd2);
      send_instr(OP_BANI, 16'h0001, 16'h8000, 2'd2);
      send_instr(OP_BORR, 16'h0002, 16'h0003, 2'd0);
      send_instr(OP_BORI, 16'h0000, 16'hFFFF, 2'd0);
      send_instr(OP_SETR, 16'hFFFE, 16'hFFFF, 2'd3);
      send_instr(OP_SETI, 16'h0000, 16'h0000, 2'd3);
      send_instr(OP_SETI, 16'h7FFF, 16'h1234, 2'd2);
      send_instr(OP_GTIR, 16'h0000, 16'h0001, 2'd0);
      send_instr(OP_GTRI, 16'h0001, 16'h0000, 2'd0);
      send_instr(OP_GTRR, 16'h0003, 16'h0001, 2'd0);
      send_instr(OP_GTRR, 16'h0001, 16'h0003, 2'd0);
      send_instr(OP_EQIR, 16'h0000, 16'h0003, 2'd0);
      send_instr(OP_EQIR, 16'hFFFF, 16'h0001, 2'd0);
      send_instr(OP_EQRI, 16'h0002, 16'h7FFF, 2'd0);
      send_instr(OP_EQRI, 16'h0002, 16'h8000, 2'd0);
      send_instr(OP_GTRI, 16'h0002, 16'hFFFF, 2'd0);
      send_instr(OP_EQRR, 16'h0001, 16'h0001, 2'd3);
      send_instr(OP_EQRR, 16'h0000, 16'h0001, 2'd3);
      wait_drained();
   endtask

   task automatic test_opcode_maps();
      logic [OPMAP_WIDTH-1:0] maps[4];
      maps[0] = '0;
      maps[1] = '1;
      maps[2] = {$urandom, $urandom};
      maps[3] = OPMAP_RESET;
      foreach (maps[m]) begin
         write_opmap(maps[m]);
         repeat (15) send_random_instr();
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         tx_idle = $urandom_range(0, 2) != 0;
         rx_idle = $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 1))
            write_opmap({$urandom, $urandom});
         repeat (55) send_random_instr();
         wait_drained();
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   // The receiver holds off while the sender keeps offering beats, so the
   // queue fills and the request side must stall.
   task automatic test_backpressure();
      tx_idle = 1'b0;
      rsp_hold_cycles = 40;
      repeat (16) send_random_instr();
      wait_drained();
      tx_idle = 1'b1;
   endtask

   task automatic test_sender_pause();
      repeat (8) send_random_instr();
      wait_drained();
      repeat (8) send_random_instr();
      wait_drained();
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= '0;
      req_bus.src_a      <= '0;
      req_bus.src_b      <= '0;
      req_bus.dest_index <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_opcode_maps();
      test_backpressure();
      test_random_traffic();
      test_sender_pause();
      wait_drained();

      if (mismatch_count == 0)
         $display("four_register_alu_executor_core: match");
      else
         $display("four_register_alu_executor_core: mismatch");
      $finish;
   end

endmodule
